[src/rrd_pkg.sv]
// Shared types and constants for the RGB565 run-length row decoder.
`default_nettype none

package rrd_pkg;

   // Control byte split between run and literal tokens
   localparam logic [7:0] LITERAL_BASE = 8'd128;
   localparam logic [7:0] LITERAL_BIAS = 8'd127;

   // One decoded result
   typedef struct packed {
      logic        malformed;
      logic        row_done;
      logic [7:0]  repeat_count;
      logic [15:0] pixel_value;
   } rsp_type;

   // Up to two results produced by one byte, in order
   typedef struct packed {
      logic    push_first;
      logic    push_second;
      rsp_type first;
      rsp_type second;
   } rsp_push_type;

endpackage

`default_nettype wire

[src/rle_rgb565_row_decoder_unit.sv]
// Top level of the RGB565 run-length row decoder.
// Usage:
//   req_* : encoded row, one byte per transfer in req_tdata, req_tlast on the
//           row's final byte.
//   rsp_* : runs of one pixel value; tdata = {repeat_count, pixel_value},
//           tlast marks the row's final result (fill or error), tuser flags
//           a malformed row that the consumer discards.
// Throughput: one byte per cycle. A byte may cause up to two results and the
//   output side moves one result per cycle, so one byte per cycle holds while
//   the results average at most one per byte and the receiver does not stall.
// Path: a byte taken is held in the input register, decoded from it, and its
//   results are written to the result queue, which offers them on rsp_*; a
//   second result of the same byte follows the first in order.
// The input register frees when the four-entry result queue has room for two
//   results; when the receiver stalls, the queue fills and req_tready drops.
// Reset clears the decoder to the start of a row and empties the queue.
`default_nettype none

module rle_rgb565_row_decoder_unit
   import rrd_pkg::*;
#(
   parameter int unsigned ROW_WIDTH = 240
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [7:0]   req_tdata,   // [7:0] raw_byte
   input  wire logic         req_tlast,   // row_end
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [23:0]       rsp_tdata,   // [15:0] pixel_value, [23:16] repeat_count
   output logic              rsp_tlast,   // row_done
   output logic              rsp_tuser    // malformed
);

   logic         stage_valid_ff, stage_valid_in;
   logic [7:0]   stage_byte_ff;
   logic         stage_last_ff;
   logic         room_for_two;
   logic         step;
   rsp_push_type push;
   rsp_type      out_rsp;

   // Input register advances when the queue can absorb both results
   assign step       = stage_valid_ff && room_for_two;
   assign req_tready = !stage_valid_ff || room_for_two;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (req_tvalid && req_tready) begin
         stage_valid_in = 1'b1;
      end else if (step) begin
         stage_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         stage_byte_ff <= req_tdata;
         stage_last_ff <= req_tlast;
      end
   end

   rrd_decoder #(
      .ROW_WIDTH (ROW_WIDTH)
   ) u_decoder (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .raw_byte (stage_byte_ff),
      .row_end  (stage_last_ff),
      .push     (push)
   );

   rrd_rsp_queue u_queue (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .room_for_two (room_for_two),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_rsp      (out_rsp)
   );

   assign rsp_tdata = {out_rsp.repeat_count, out_rsp.pixel_value};
   assign rsp_tlast = out_rsp.row_done;
   assign rsp_tuser = out_rsp.malformed;

endmodule

`default_nettype wire

[src/rrd_decoder.sv]
// Token state machine: turns one encoded byte into at most two results.
`default_nettype none

module rrd_decoder
   import rrd_pkg::*;
#(
   parameter int unsigned ROW_WIDTH = 240
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         step,       // byte in the stage is consumed this cycle
   input  wire logic [7:0]   raw_byte,
   input  wire logic         row_end,
   output rsp_push_type      push
);

   localparam logic [7:0] WIDTH8 = ROW_WIDTH[7:0];

   typedef enum logic [3:0] {
      PH_CTRL = 4'b0001,
      PH_LOW  = 4'b0010,
      PH_HIGH = 4'b0100,
      PH_FULL = 4'b1000
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic       literal_ff, literal_in;
   logic [7:0] left_ff, left_in;
   logic [7:0] low_ff, low_in;
   logic [7:0] pos_ff, pos_in;

   logic [7:0] room;
   logic [7:0] run_cnt;
   logic [7:0] left_dec;
   logic       token_over;

   // Clipping arithmetic for the pixel completed by a high byte
   assign room     = (pos_ff < WIDTH8) ? (WIDTH8 - pos_ff) : 8'd0;
   assign run_cnt  = (left_ff < room) ? left_ff : room;
   assign left_dec = (left_ff != 8'd0) ? (left_ff - 8'd1) : 8'd0;

   always_comb begin
      phase_in   = phase_ff;
      literal_in = literal_ff;
      left_in    = left_ff;
      low_in     = low_ff;
      pos_in     = pos_ff;
      token_over = 1'b0;
      push       = '0;

      case (phase_ff)
         PH_CTRL: begin
            if (raw_byte < LITERAL_BASE) begin
               literal_in = 1'b0;
               left_in    = {1'b0, raw_byte[6:0]} + 8'd1;
            end else begin
               literal_in = 1'b1;
               left_in    = raw_byte - LITERAL_BIAS;
            end
            phase_in = PH_LOW;
         end
         PH_LOW: begin
            low_in   = raw_byte;
            phase_in = PH_HIGH;
         end
         PH_HIGH: begin
            push.first.pixel_value = {raw_byte, low_ff};
            if (literal_ff) begin
               push.first.repeat_count = 8'd1;
               push.push_first         = (room != 8'd0);
               pos_in                  = pos_ff + ((room != 8'd0) ? 8'd1 : 8'd0);
               left_in                 = left_dec;
               token_over              = (left_dec == 8'd0);
            end else begin
               push.first.repeat_count = run_cnt;
               push.push_first         = (run_cnt != 8'd0);
               pos_in                  = pos_ff + run_cnt;
               left_in                 = 8'd0;
               token_over              = 1'b1;
            end
            if (token_over) begin
               phase_in = (pos_in >= WIDTH8) ? PH_FULL : PH_CTRL;
            end else begin
               phase_in = PH_LOW;
            end
         end
         PH_FULL: begin
            phase_in = PH_FULL;
         end
         default: begin
            phase_in = PH_CTRL;
         end
      endcase

      // Row end: error if inside a token, otherwise zero fill to the width
      if (row_end) begin
         push.push_second         = 1'b1;
         push.second.pixel_value  = 16'd0;
         push.second.row_done     = 1'b1;
         if ((phase_in == PH_LOW) || (phase_in == PH_HIGH)) begin
            push.second.malformed    = 1'b1;
            push.second.repeat_count = 8'd0;
         end else begin
            push.second.repeat_count = (pos_in < WIDTH8) ? (WIDTH8 - pos_in) : 8'd0;
         end
         phase_in   = PH_CTRL;
         literal_in = 1'b0;
         left_in    = 8'd0;
         low_in     = 8'd0;
         pos_in     = 8'd0;
      end

      if (!step) begin
         push.push_first  = 1'b0;
         push.push_second = 1'b0;
      end
   end

   // Decoder state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_CTRL;
         literal_ff <= 1'b0;
         left_ff    <= 8'd0;
         pos_ff     <= 8'd0;
      end else if (step) begin
         phase_ff   <= phase_in;
         literal_ff <= literal_in;
         left_ff    <= left_in;
         pos_ff     <= pos_in;
      end
   end

   // Held low byte, always written before it is read
   always_ff @(posedge clock) begin
      if (step) begin
         low_ff <= low_in;
      end
   end

endmodule

`default_nettype wire

[src/rrd_rsp_queue.sv]
// Four-entry result queue that takes up to two results per cycle.
`default_nettype none

module rrd_rsp_queue
   import rrd_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire rsp_push_type  push,
   output logic               room_for_two,
   output logic               out_valid,
   input  wire logic          out_ready,
   output rsp_type            out_rsp
);

   rsp_type    mem_ff [4];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff, count_in;
   logic       pop;
   logic [1:0] n_push;
   logic [1:0] wr_next;

   assign out_valid    = (count_ff != 3'd0);
   assign out_rsp      = mem_ff[rd_ptr_ff];
   assign room_for_two = (count_ff <= 3'd2);
   assign pop          = out_valid && out_ready;
   assign n_push       = {1'b0, push.push_first} + {1'b0, push.push_second};
   assign wr_next      = wr_ptr_ff + 2'd1;

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff + n_push;
      rd_ptr_in = rd_ptr_ff + {1'b0, pop};
      count_in  = count_ff + {1'b0, n_push} - {2'b00, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         count_ff  <= 3'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Packed writes: the first pushed result lands at the write pointer
   always_ff @(posedge clock) begin
      if (push.push_first) begin
         mem_ff[wr_ptr_ff] <= push.first;
         if (push.push_second) begin
            mem_ff[wr_next] <= push.second;
         end
      end else if (push.push_second) begin
         mem_ff[wr_ptr_ff] <= push.second;
      end
   end

endmodule

`default_nettype wire

[src/rrd_checker.sv]
// Port-level checks for the row decoder, bound to its top level.
`default_nettype none

module rrd_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [23:0] rsp_tdata,
   input wire logic        rsp_tlast,
   input wire logic        rsp_tuser
);

   // Reset empties the result queue
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result offered right after reset");

   // Stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)
                                       && $stable(rsp_tlast) && $stable(rsp_tuser)))
      else $error("stalled result changed");

   // An error result ends the row and carries no pixels
   a_error_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tlast && (rsp_tdata == 24'd0)))
      else $error("malformed result not a bare row end");

   // Pixel results always cover at least one pixel
   a_pixel_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tlast) |-> (rsp_tdata[23:16] != 8'd0))
      else $error("pixel result with zero count");

endmodule

bind rle_rgb565_row_decoder_unit rrd_checker u_rrd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
